### rtl/core/alft_pkg.sv
// Shared types and constants for the address-space LRU frame table.
package alft_pkg;

  localparam int CFG_DATA_W  = 8;
  localparam int COUNT_W     = 32;
  localparam int INDEX_OUT_W = 7;

  localparam logic [CFG_DATA_W-1:0] FRAMES_RESET = 8'd128;

  // Configuration register indexes.
  localparam logic REG_SHARED_MODE   = 1'b0;
  localparam logic REG_FRAMES_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Control part of the search record that walks down the cell chain.
  typedef struct packed {
    logic live;
    logic found;
    logic hit;
    logic best_set;
  } scan_flags_t;

  // Write-back command broadcast to all cells.
  typedef struct packed {
    logic write;
    logic refill;
  } wb_ctl_t;

endpackage

### rtl/core/alft_cell.sv
// One frame of the table plus its stage of the search chain.
module alft_cell
  import alft_pkg::*;
#(
  parameter int CELL_IDX   = 0,
  parameter int IDX_W      = 7,
  parameter int CNT_W      = 8,
  parameter int PAGE_BITS  = 20,
  parameter int STAMP_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CNT_W-1:0]      lo,
  input  logic [CNT_W-1:0]      hi,
  input  logic [PAGE_BITS-1:0]  req_page,
  input  logic                  req_space,
  input  scan_flags_t           flags_in,
  input  logic [IDX_W-1:0]      sel_in,
  input  logic [IDX_W-1:0]      best_idx_in,
  input  logic [STAMP_BITS-1:0] best_stamp_in,
  input  logic [PAGE_BITS-1:0]  best_page_in,
  output scan_flags_t           flags_out,
  output logic [IDX_W-1:0]      sel_out,
  output logic [IDX_W-1:0]      best_idx_out,
  output logic [STAMP_BITS-1:0] best_stamp_out,
  output logic [PAGE_BITS-1:0]  best_page_out,
  input  wb_ctl_t               wb,
  input  logic [IDX_W-1:0]      wb_idx,
  input  logic [PAGE_BITS-1:0]  wb_page,
  input  logic                  wb_space,
  input  logic [STAMP_BITS-1:0] wb_stamp
);

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] MY_SEL = IDX_W'(CELL_IDX);

  logic                  valid;
  logic [PAGE_BITS-1:0]  page;
  logic                  space;
  logic [STAMP_BITS-1:0] stamp;

  logic                  in_range;
  logic                  take_best;
  scan_flags_t           flags_next;
  logic [IDX_W-1:0]      sel_next;
  logic [IDX_W-1:0]      best_idx_next;
  logic [STAMP_BITS-1:0] best_stamp_next;
  logic [PAGE_BITS-1:0]  best_page_next;

  always_comb begin
    in_range  = flags_in.live && (MY_POS >= lo) && (MY_POS < hi);
    take_best = in_range && (!flags_in.best_set || (stamp < best_stamp_in));

    flags_next      = flags_in;
    sel_next        = sel_in;
    best_idx_next   = best_idx_in;
    best_stamp_next = best_stamp_in;
    best_page_next  = best_page_in;

    // The first empty or matching frame in range ends the search.
    if (in_range && !flags_in.found) begin
      if (!valid) begin
        flags_next.found = 1'b1;
        sel_next         = MY_SEL;
      end else if ((page == req_page) && (space == req_space)) begin
        flags_next.found = 1'b1;
        flags_next.hit   = 1'b1;
        sel_next         = MY_SEL;
      end
    end

    // Strict compare keeps the lowest index on equal stamps.
    if (take_best) begin
      flags_next.best_set = 1'b1;
      best_idx_next       = MY_SEL;
      best_stamp_next     = stamp;
      best_page_next      = page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out <= '0;
    end else begin
      flags_out <= flags_next;
    end
    sel_out        <= sel_next;
    best_idx_out   <= best_idx_next;
    best_stamp_out <= best_stamp_next;
    best_page_out  <= best_page_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wb.write && wb.refill && (wb_idx == MY_SEL)) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wb.write && (wb_idx == MY_SEL)) begin
      stamp <= wb_stamp;
      if (wb.refill) begin
        page  <= wb_page;
        space <= wb_space;
      end
    end
  end

endmodule

### rtl/core/asid_lru_frame_table.sv
// Top level of the address-space LRU frame table: control, counters and the cell chain.
// Each access word is looked up by a search record that walks the row of frame cells, one
// cell per clock, checking for an empty or matching frame and tracking the oldest stamp on
// the way; the next word is accepted only after the record has left the last cell and the
// result has been written back. A finished result sits in an output register, so the next
// word can be taken and searched while the previous result still waits; a result that finds
// the register still full holds its write-back until the register frees. The table is empty
// after reset, with no clearing pass.
module asid_lru_frame_table
  import alft_pkg::*;
#(
  parameter int MAX_FRAMES = 128,
  parameter int PAGE_BITS  = 20,
  parameter int STAMP_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   space_id,
  input  logic [PAGE_BITS-1:0]   page_number,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic                   hit,
  output logic [INDEX_OUT_W-1:0] frame_index,
  output logic                   evicted,
  output logic [PAGE_BITS-1:0]   evicted_page,
  output logic [COUNT_W-1:0]     fault_total,
  output logic [COUNT_W-1:0]     hit_total
);

  localparam int IDX_W  = $clog2(MAX_FRAMES);
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int WIDE_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
  localparam int EXT_W  = IDX_W + INDEX_OUT_W;

  state_t state, state_next;

  logic                  shared_mode;
  logic [CFG_DATA_W-1:0] frames_in_use;
  logic [STAMP_BITS-1:0] access_clock;
  logic [COUNT_W-1:0]    fault_count;
  logic [COUNT_W-1:0]    hit_count;

  logic [PAGE_BITS-1:0]  req_page;
  logic                  req_space;
  logic [CNT_W-1:0]      lo;
  logic [CNT_W-1:0]      hi;
  logic                  launch;

  logic                  res_hit;
  logic                  res_evict;
  logic [IDX_W-1:0]      res_idx;
  logic [PAGE_BITS-1:0]  res_old_page;

  logic [WIDE_W-1:0]     n_wide;
  logic [CNT_W-1:0]      n_eff;
  logic [CNT_W-1:0]      lo_next;
  logic [CNT_W-1:0]      hi_next;
  logic                  accept;
  logic                  slot_free;
  logic                  tail_live;
  wb_ctl_t               wb;
  logic [EXT_W-1:0]      idx_ext;

  scan_flags_t           link_flags      [0:MAX_FRAMES];
  logic [IDX_W-1:0]      link_sel        [0:MAX_FRAMES];
  logic [IDX_W-1:0]      link_best_idx   [0:MAX_FRAMES];
  logic [STAMP_BITS-1:0] link_best_stamp [0:MAX_FRAMES];
  logic [PAGE_BITS-1:0]  link_best_page  [0:MAX_FRAMES];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      shared_mode   <= 1'b0;
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_SHARED_MODE:   shared_mode   <= cfg_data[0];
        REG_FRAMES_IN_USE: frames_in_use <= cfg_data;
        default:           shared_mode   <= shared_mode;
      endcase
    end
  end

  // Clamp the frame count and pick the window for this address space.
  always_comb begin
    n_wide = WIDE_W'(frames_in_use);
    if (n_wide > WIDE_W'(MAX_FRAMES)) begin
      n_eff = CNT_W'(MAX_FRAMES);
    end else if (n_wide < WIDE_W'(2)) begin
      n_eff = CNT_W'(2);
    end else begin
      n_eff = n_wide[CNT_W-1:0];
    end
    if (shared_mode) begin
      lo_next = '0;
      hi_next = n_eff;
    end else if (!space_id) begin
      lo_next = '0;
      hi_next = n_eff >> 1;
    end else begin
      lo_next = n_eff >> 1;
      hi_next = n_eff;
    end
  end

  assign accept    = item_valid && item_ready;
  assign slot_free = !result_valid || result_ready;
  assign tail_live = link_flags[MAX_FRAMES].live;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: if (tail_live) state_next = ST_DONE;
      ST_DONE: if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    wb         = '0;
    unique case (state)
      ST_IDLE: item_ready = 1'b1;
      ST_SCAN: wb = '0;
      ST_DONE: begin
        wb.write  = slot_free;
        wb.refill = !res_hit;
      end
      default: item_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_page  <= page_number;
      req_space <= space_id;
      lo        <= lo_next;
      hi        <= hi_next;
    end
  end

  // Head of the chain: a fresh search record.
  always_comb begin
    link_flags[0]       = '0;
    link_flags[0].live  = launch;
    link_sel[0]         = '0;
    link_best_idx[0]    = '0;
    link_best_stamp[0]  = '0;
    link_best_page[0]   = '0;
  end

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    alft_cell #(
      .CELL_IDX   (g),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .PAGE_BITS  (PAGE_BITS),
      .STAMP_BITS (STAMP_BITS)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .lo             (lo),
      .hi             (hi),
      .req_page       (req_page),
      .req_space      (req_space),
      .flags_in       (link_flags[g]),
      .sel_in         (link_sel[g]),
      .best_idx_in    (link_best_idx[g]),
      .best_stamp_in  (link_best_stamp[g]),
      .best_page_in   (link_best_page[g]),
      .flags_out      (link_flags[g+1]),
      .sel_out        (link_sel[g+1]),
      .best_idx_out   (link_best_idx[g+1]),
      .best_stamp_out (link_best_stamp[g+1]),
      .best_page_out  (link_best_page[g+1]),
      .wb             (wb),
      .wb_idx         (res_idx),
      .wb_page        (req_page),
      .wb_space       (req_space),
      .wb_stamp       (access_clock)
    );
  end

  // Settle the outcome when the record leaves the last cell.
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && tail_live) begin
      res_hit   <= link_flags[MAX_FRAMES].hit;
      res_evict <= !link_flags[MAX_FRAMES].found;
      if (link_flags[MAX_FRAMES].found) begin
        res_idx      <= link_sel[MAX_FRAMES];
        res_old_page <= '0;
      end else begin
        res_idx      <= link_best_idx[MAX_FRAMES];
        res_old_page <= link_best_page[MAX_FRAMES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock <= '0;
      fault_count  <= '0;
      hit_count    <= '0;
    end else if (wb.write) begin
      access_clock <= access_clock + STAMP_BITS'(1);
      if (res_hit) begin
        if (hit_count != '1) hit_count <= hit_count + COUNT_W'(1);
      end else begin
        if (fault_count != '1) fault_count <= fault_count + COUNT_W'(1);
      end
    end
  end

  assign idx_ext = EXT_W'(res_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (wb.write) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb.write) begin
      hit          <= res_hit;
      frame_index  <= idx_ext[INDEX_OUT_W-1:0];
      evicted      <= res_evict;
      evicted_page <= res_old_page;
      fault_total  <= (res_hit || (fault_count == '1)) ? fault_count
                                                       : fault_count + COUNT_W'(1);
      hit_total    <= (!res_hit || (hit_count == '1)) ? hit_count
                                                      : hit_count + COUNT_W'(1);
    end
  end

  a_hit_not_evicted: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(hit && evicted))
    else $error("hit and eviction reported for the same word");

  a_evicted_page_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !evicted) |-> (evicted_page == '0))
    else $error("evicted page nonzero without an eviction");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail_live |-> (state == ST_SCAN))
    else $error("search record left the chain outside of a scan");

  a_clock_advances: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> (access_clock == $past(access_clock) + STAMP_BITS'(1)))
    else $error("access clock did not advance with a finished word");

endmodule

### test/tb_asid_lru_frame_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for the address-space LRU frame table, with scoreboard and drivers.
module tb_asid_lru_frame_table;
  import alft_pkg::*;

  localparam int TABLE_DEPTH    = 128;
  localparam int PAGE_W         = 20;
  localparam int PHASE_COUNT    = 14;
  localparam int PHASE_ITEMS    = 130;
  localparam int HOLD_CYCLES    = 700;
  localparam int SETTLE_CYCLES  = TABLE_DEPTH + 3 + 20;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic                   hit;
    logic [INDEX_OUT_W-1:0] frame;
    logic                   evicted;
    logic [PAGE_W-1:0]      old_page;
    logic [COUNT_W-1:0]     faults;
    logic [COUNT_W-1:0]     hits;
  } lookup_result_t;

  class frame_table_checker;
    bit                  slot_valid [TABLE_DEPTH];
    bit [PAGE_W-1:0]     slot_page  [TABLE_DEPTH];
    bit                  slot_space [TABLE_DEPTH];
    bit [31:0]           slot_stamp [TABLE_DEPTH];
    bit [31:0]           use_clock;
    bit [COUNT_W-1:0]    fault_cnt;
    bit [COUNT_W-1:0]    hit_cnt;
    bit                  shared;
    bit [CFG_DATA_W-1:0] frames_reg;
    lookup_result_t      pending_lookups[$];
    int                  errors;

    function new();
      foreach (slot_valid[i]) begin
        slot_valid[i] = 0;
        slot_page[i]  = '0;
        slot_space[i] = 0;
        slot_stamp[i] = '0;
      end
      use_clock  = '0;
      fault_cnt  = '0;
      hit_cnt    = '0;
      shared     = 0;
      frames_reg = FRAMES_RESET;
      errors     = 0;
    endfunction

    function void set_register(logic idx, bit [CFG_DATA_W-1:0] data);
      if (idx == REG_SHARED_MODE) shared = data[0];
      else frames_reg = data;
    endfunction

    function void note_access(bit sid, bit [PAGE_W-1:0] page);
      int             n, lo, hi, sel;
      bit             found, is_hit;
      bit [31:0]      best;
      lookup_result_t r;
      n = int'(frames_reg);
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      if (n < 2) n = 2;
      if (shared) begin
        lo = 0;
        hi = n;
      end else if (!sid) begin
        lo = 0;
        hi = n / 2;
      end else begin
        lo = n / 2;
        hi = n;
      end
      found  = 0;
      is_hit = 0;
      sel    = lo;
      r.evicted  = 0;
      r.old_page = '0;
      // The first empty frame and the first matching frame compete in scan order.
      for (int i = lo; i < hi; i++) begin
        if (!slot_valid[i]) begin
          sel   = i;
          found = 1;
          break;
        end
        if (slot_page[i] == page && slot_space[i] == sid) begin
          sel    = i;
          found  = 1;
          is_hit = 1;
          break;
        end
      end
      if (!found) begin
        best = slot_stamp[lo];
        sel  = lo;
        for (int i = lo + 1; i < hi; i++) begin
          if (slot_stamp[i] < best) begin
            best = slot_stamp[i];
            sel  = i;
          end
        end
        r.evicted  = 1;
        r.old_page = slot_page[sel];
      end
      if (is_hit) begin
        if (hit_cnt != '1) hit_cnt++;
      end else begin
        if (fault_cnt != '1) fault_cnt++;
        slot_valid[sel] = 1;
        slot_page[sel]  = page;
        slot_space[sel] = sid;
      end
      slot_stamp[sel] = use_clock;
      use_clock++;
      r.hit    = is_hit;
      r.frame  = sel[INDEX_OUT_W-1:0];
      r.faults = fault_cnt;
      r.hits   = hit_cnt;
      pending_lookups.push_back(r);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (pending_lookups.size() == 0) begin
        $error("result word arrived with no access pending");
        errors++;
        return;
      end
      want = pending_lookups.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        errors++;
      end
      if (got.frame !== want.frame) begin
        $error("frame_index: expected %0d, got %0d", want.frame, got.frame);
        errors++;
      end
      if (got.evicted !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
        errors++;
      end
      if (got.old_page !== want.old_page) begin
        $error("evicted_page: expected %05h, got %05h", want.old_page, got.old_page);
        errors++;
      end
      if (got.faults !== want.faults) begin
        $error("fault_total: expected %0d, got %0d", want.faults, got.faults);
        errors++;
      end
      if (got.hits !== want.hits) begin
        $error("hit_total: expected %0d, got %0d", want.hits, got.hits);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write_en;
  logic                   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   item_valid;
  logic                   item_ready;
  logic                   space_id;
  logic [PAGE_W-1:0]      page_number;
  logic                   result_valid;
  logic                   result_ready;
  logic                   hit;
  logic [INDEX_OUT_W-1:0] frame_index;
  logic                   evicted;
  logic [PAGE_W-1:0]      evicted_page;
  logic [COUNT_W-1:0]     fault_total;
  logic [COUNT_W-1:0]     hit_total;

  frame_table_checker checker_h = new();
  int burst_left = 0;
  int quiet_cycles = 0;

  asid_lru_frame_table dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .space_id     (space_id),
    .page_number  (page_number),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .hit          (hit),
    .frame_index  (frame_index),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .fault_total  (fault_total),
    .hit_total    (hit_total)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one access word, opening a random gap first when the current burst is used up.
  task automatic send_access(input bit sid, input bit [PAGE_W-1:0] page);
    int gap;
    int roll;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      roll = $urandom_range(0, 99);
      if (roll < 50) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 8);
      else gap = $urandom_range(9, 160);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    item_valid  <= 1'b1;
    space_id    <= sid;
    page_number <= page;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    checker_h.note_access(sid, page);
    burst_left--;
  endtask

  task automatic drain();
    while (checker_h.pending_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on back-to-back edges while the table is idle.
  task automatic configure(input bit shared, input bit [CFG_DATA_W-1:0] frames);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_SHARED_MODE;
    cfg_data     <= {{(CFG_DATA_W-1){1'b0}}, shared};
    @(posedge clk);
    checker_h.set_register(REG_SHARED_MODE, {{(CFG_DATA_W-1){1'b0}}, shared});
    cfg_index <= REG_FRAMES_IN_USE;
    cfg_data  <= frames;
    @(posedge clk);
    checker_h.set_register(REG_FRAMES_IN_USE, frames);
    cfg_write_en <= 1'b0;
  endtask

  // Receiver: stall pattern changes mode now and then, with one long hold-off early on.
  initial begin
    int             seen;
    int             mode;
    int             mode_left;
    bit             held_off;
    bit             toggle;
    lookup_result_t got;
    seen      = 0;
    mode      = 0;
    mode_left = 0;
    held_off  = 0;
    toggle    = 0;
    result_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) begin
        got.hit      = hit;
        got.frame    = frame_index;
        got.evicted  = evicted;
        got.old_page = evicted_page;
        got.faults   = fault_total;
        got.hits     = hit_total;
        checker_h.check_result(got);
        seen++;
      end
      if (!held_off && seen >= 40) begin
        held_off = 1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 300);
      end
      mode_left--;
      toggle = !toggle;
      case (mode)
        0: result_ready <= 1'b1;
        1: result_ready <= 1'($urandom_range(0, 1));
        2: result_ready <= ($urandom_range(0, 9) == 0);
        default: result_ready <= toggle;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    bit                  shared_list [PHASE_COUNT];
    bit [CFG_DATA_W-1:0] frames_list [PHASE_COUNT];
    bit [PAGE_W-1:0]     pool [256];
    int                  eff, pool_size;
    bit [PAGE_W-1:0]     page;
    shared_list = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
    frames_list = '{128, 128, 2, 2, 9, 31, 0, 1, 255, 129, 64, 16, 128, 7};
    rst          = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index    = REG_SHARED_MODE;
    cfg_data     = '0;
    item_valid   = 1'b0;
    space_id     = 1'b0;
    page_number  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: split halves of all 128 frames.
    send_access(1'b1, 20'h00000);
    send_access(1'b0, 20'hFFFFF);
    item_valid <= 1'b0;
    drain();

    // Two frames per space: fill, hit, and LRU eviction; same page in the other space misses.
    configure(1'b0, 8'd4);
    send_access(1'b0, 20'h00000);
    send_access(1'b0, 20'hFFFFF);
    send_access(1'b0, 20'h12345);
    send_access(1'b1, 20'h00000);
    send_access(1'b1, 20'h00000);
    send_access(1'b1, 20'hFFFFF);
    send_access(1'b1, 20'hAAAAA);
    item_valid <= 1'b0;
    drain();

    // Growing into shared mode leaves empty frames after the resident ones.
    configure(1'b1, 8'd8);
    send_access(1'b0, 20'h12345);
    send_access(1'b1, 20'h12345);
    send_access(1'b0, 20'hAAAAA);
    item_valid <= 1'b0;
    drain();

    // Odd frame count in split mode gives the upper space the extra frame.
    configure(1'b0, 8'd5);
    send_access(1'b0, 20'h55555);
    send_access(1'b1, 20'h0F0F0);
    item_valid <= 1'b0;
    drain();

    // Out-of-range frame counts clamp to the table depth and to two.
    configure(1'b1, 8'd255);
    send_access(1'b1, 20'hFFFFF);
    send_access(1'b0, 20'h0F0F0);
    item_valid <= 1'b0;
    drain();
    configure(1'b0, 8'd0);
    send_access(1'b0, 20'h00000);
    send_access(1'b1, 20'h00000);
    item_valid <= 1'b0;
    drain();
    configure(1'b1, 8'd1);
    send_access(1'b1, 20'h00000);
    item_valid <= 1'b0;
    drain();

    // Random phases: pages mostly from a per-phase working set sized around the frame count.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      configure(shared_list[p], frames_list[p]);
      eff = int'(frames_list[p]);
      if (eff > TABLE_DEPTH) eff = TABLE_DEPTH;
      if (eff < 2) eff = 2;
      pool_size = $urandom_range(2, 2 * eff + 2);
      if (pool_size > 256) pool_size = 256;
      for (int k = 0; k < pool_size; k++) pool[k] = PAGE_W'($urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 85) page = pool[$urandom_range(0, pool_size - 1)];
        else page = PAGE_W'($urandom);
        send_access(1'($urandom_range(0, 1)), page);
      end
      item_valid <= 1'b0;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (checker_h.errors == 0 && checker_h.pending_lookups.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
